// File: rtl/assert_macros.svh
// assertion macros for the checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while reset is high
`define MRC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds through reset
`define MRC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/mrc_pkg.sv
// shared types, constants and helpers for the mixed-radix index converter
// no dependencies
`default_nettype none

package mrc_pkg;

   localparam int IDX_W      = 32;
   localparam int LOCI_MAX   = 16;
   localparam int LOCUS_W    = 4;
   localparam int DIG_W      = 4;
   localparam int CNT_W      = 5;
   localparam int LIST_W     = LOCI_MAX * DIG_W;
   localparam int STEP_BITS  = 4;
   localparam int STEPS      = IDX_W / STEP_BITS;
   localparam int STEP_CNT_W = $clog2(STEPS);
   localparam int REQ_W      = 40;
   localparam int RSP_W      = 40;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_W      = 64;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_LOCUS_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_RADIX_LIST  = 1'b1;

   // operation codes carried in req_tuser
   localparam logic OP_DECODE = 1'b0;
   localparam logic OP_ENCODE = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      UOP_HOLD,
      UOP_LOAD,
      UOP_CLEAR,
      UOP_STEP
   } uop_type;

   typedef struct packed {
      uop_type          op;
      logic [DIG_W-1:0] radix;
   } unit_ctl_type;

   // radix nibble of one locus, a zero nibble acting as one
   function automatic logic [DIG_W-1:0] radix_sel(input logic [LIST_W-1:0] list,
                                                  input logic [LOCUS_W-1:0] locus);
      logic [DIG_W-1:0] r;
      r = list[locus*DIG_W +: DIG_W];
      return (r == '0) ? DIG_W'(1) : r;
   endfunction

   // clamp the locus count to 1..LOCI_MAX
   function automatic logic [CNT_W-1:0] loci_in_use(input logic [CNT_W-1:0] count);
      logic [CNT_W-1:0] n;
      n = count;
      if (n == '0) n = CNT_W'(1);
      if (n > CNT_W'(LOCI_MAX)) n = CNT_W'(LOCI_MAX);
      return n;
   endfunction

endpackage

`default_nettype wire

// File: rtl/mrc_radix_unit.sv
// shared radix arithmetic: iterative divide by a 4-bit radix, 4 quotient bits per cycle
// while stepping, plus the multiply-accumulate used by encode; depends on mrc_pkg
`default_nettype none

module mrc_radix_unit
   import mrc_pkg::*;
(
   input  wire logic               clock,
   input  wire unit_ctl_type       ctl,
   input  wire logic [IDX_W-1:0]   load_value,
   input  wire logic [IDX_W-1:0]   mac_acc,
   input  wire logic [DIG_W-1:0]   mac_digit,
   output logic [DIG_W-1:0]        step_rem,
   output logic [IDX_W-1:0]        mac_sum
);

   logic [IDX_W-1:0] work_ff, work_in;
   logic [DIG_W-1:0] rem_ff, rem_in;
   logic [IDX_W-1:0] step_work;

   // four restoring division steps on the running remainder
   always_comb begin
      logic [IDX_W-1:0] w;
      logic [DIG_W-1:0] r;
      logic [DIG_W:0]   part;
      w = work_ff;
      r = rem_ff;
      for (int i = 0; i < STEP_BITS; i++) begin
         part = {r, w[IDX_W-1]};
         w    = {w[IDX_W-2:0], 1'b0};
         if (part >= {1'b0, ctl.radix}) begin
            part = part - {1'b0, ctl.radix};
            w[0] = 1'b1;
         end
         r = part[DIG_W-1:0];
      end
      step_work = w;
      step_rem  = r;
   end

   // encode fold, wrapping at the index width
   always_comb begin
      logic [IDX_W-1:0] prod;
      prod    = mac_acc * IDX_W'(ctl.radix);
      mac_sum = prod + IDX_W'(mac_digit);
   end

   // work register update
   always_comb begin
      work_in = work_ff;
      rem_in  = rem_ff;
      case (ctl.op)
         UOP_LOAD: begin
            work_in = load_value;
            rem_in  = '0;
         end
         UOP_CLEAR: begin
            rem_in = '0;
         end
         UOP_STEP: begin
            work_in = step_work;
            rem_in  = step_rem;
         end
         default: begin
            work_in = work_ff;
            rem_in  = rem_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      rem_ff  <= rem_in;
   end

endmodule

`default_nettype wire

// File: rtl/mixed_radix_index_converter.sv
// mixed-radix index converter top level: sequencer, config registers, result register
// depends on mrc_pkg and mrc_radix_unit
//
//   channel  | direction | ports            | contents
//   req      | in        | req_t*           | tdata: index[31:0], digit[35:32]; tuser: op
//   rsp      | out       | rsp_t*           | tdata: locus, digit_out, index_out; tlast: last
//   csr      | in        | csr_*            | index 0 locus_count, 1 radix_list
//
// decode divides the index by each locus radix in turn, starting on the highest locus: the shared
// divider retires 4 quotient bits per cycle, and each digit is shown as one result item.
// encode folds each accepted digit into the accumulator; the result follows the final locus.
// req_tready is high only while idle; a stalled result holds the sequencer.
// reset is synchronous; it clears the accumulator, position and registers to their defaults.
`default_nettype none

module mixed_radix_index_converter
   import mrc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [REQ_W-1:0]     req_tdata,   // index[31:0], digit[35:32], zero pad
   input  wire logic                 req_tuser,   // op
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [RSP_W-1:0]          rsp_tdata,   // locus[3:0], digit_out[7:4], index_out[39:8]
   output logic                      rsp_tlast,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_data
);

   state_type state_ff, state_in;

   logic [CNT_W-1:0]      locus_count_ff, locus_count_in;
   logic [LIST_W-1:0]     radix_list_ff, radix_list_in;
   logic [IDX_W-1:0]      acc_ff, acc_in;
   logic [LOCUS_W-1:0]    pos_ff, pos_in;
   logic [LOCUS_W-1:0]    locus_ff, locus_in;
   logic [STEP_CNT_W-1:0] step_ff, step_in;

   logic [LOCUS_W-1:0]    rsp_locus_ff, rsp_locus_in;
   logic [DIG_W-1:0]      rsp_digit_ff, rsp_digit_in;
   logic [IDX_W-1:0]      rsp_index_ff, rsp_index_in;
   logic                  rsp_last_ff, rsp_last_in;

   unit_ctl_type          ctl;
   logic [DIG_W-1:0]      step_rem;
   logic [IDX_W-1:0]      mac_sum;

   logic [CNT_W-1:0]      n_loci;
   logic                  req_fire;
   logic                  rsp_fire;
   logic [IDX_W-1:0]      req_index;
   logic [DIG_W-1:0]      req_digit;

   assign n_loci    = loci_in_use(locus_count_ff);
   assign req_index = req_tdata[IDX_W-1:0];
   assign req_digit = req_tdata[IDX_W +: DIG_W];
   assign req_fire  = req_tvalid && req_tready;
   assign rsp_fire  = rsp_tvalid && rsp_tready;

   mrc_radix_unit u_unit (
      .clock      (clock),
      .ctl        (ctl),
      .load_value (req_index),
      .mac_acc    (acc_ff),
      .mac_digit  (req_digit),
      .step_rem   (step_rem),
      .mac_sum    (mac_sum)
   );

   // configuration writes
   assign csr_ready = 1'b1;

   always_comb begin
      locus_count_in = locus_count_ff;
      radix_list_in  = radix_list_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_LOCUS_COUNT: locus_count_in = csr_data[CNT_W-1:0];
            REG_RADIX_LIST:  radix_list_in  = csr_data[LIST_W-1:0];
            default: begin
               locus_count_in = locus_count_ff;
               radix_list_in  = radix_list_ff;
            end
         endcase
      end
   end

   // sequencer: next state and unit control
   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      pos_in       = pos_ff;
      locus_in     = locus_ff;
      step_in      = step_ff;
      rsp_locus_in = rsp_locus_ff;
      rsp_digit_in = rsp_digit_ff;
      rsp_index_in = rsp_index_ff;
      rsp_last_in  = rsp_last_ff;
      ctl.op       = UOP_HOLD;
      ctl.radix    = radix_sel(radix_list_ff, locus_ff);
      req_tready   = 1'b0;
      rsp_tvalid   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            ctl.radix  = radix_sel(radix_list_ff, pos_ff);
            if (req_fire) begin
               if (req_tuser == OP_DECODE) begin
                  // start on the highest locus
                  ctl.op   = UOP_LOAD;
                  locus_in = LOCUS_W'(n_loci - CNT_W'(1));
                  step_in  = '0;
                  state_in = ST_DIV;
               end else if ({1'b0, pos_ff} + CNT_W'(1) >= n_loci) begin
                  // final digit of the run
                  rsp_locus_in = LOCUS_W'(n_loci - CNT_W'(1));
                  rsp_digit_in = req_digit;
                  rsp_index_in = mac_sum;
                  rsp_last_in  = 1'b1;
                  acc_in       = '0;
                  pos_in       = '0;
                  state_in     = ST_OUT;
               end else begin
                  acc_in = mac_sum;
                  pos_in = pos_ff + LOCUS_W'(1);
               end
            end
         end

         ST_DIV: begin
            ctl.op  = UOP_STEP;
            step_in = step_ff + STEP_CNT_W'(1);
            if (step_ff == STEP_CNT_W'(STEPS - 1)) begin
               rsp_locus_in = locus_ff;
               rsp_digit_in = step_rem;
               rsp_index_in = '0;
               rsp_last_in  = (locus_ff == '0);
               state_in     = ST_OUT;
            end
         end

         ST_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_fire) begin
               if (rsp_last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  // quotient stays in the unit as the next dividend
                  ctl.op   = UOP_CLEAR;
                  locus_in = locus_ff - LOCUS_W'(1);
                  step_in  = '0;
                  state_in = ST_DIV;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and model state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         locus_count_ff <= CNT_W'(1);
         radix_list_ff  <= 64'h2222_2222_2222_2222;
         acc_ff         <= '0;
         pos_ff         <= '0;
      end else begin
         state_ff       <= state_in;
         locus_count_ff <= locus_count_in;
         radix_list_ff  <= radix_list_in;
         acc_ff         <= acc_in;
         pos_ff         <= pos_in;
      end
   end

   // sequencing counters and result payload
   always_ff @(posedge clock) begin
      locus_ff     <= locus_in;
      step_ff      <= step_in;
      rsp_locus_ff <= rsp_locus_in;
      rsp_digit_ff <= rsp_digit_in;
      rsp_index_ff <= rsp_index_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tdata = {rsp_index_ff, rsp_digit_ff, rsp_locus_ff};
   assign rsp_tlast = rsp_last_ff;

endmodule

`default_nettype wire

// File: rtl/mrc_checker.sv
// port-level checks for the mixed-radix index converter, bound to the top level
// depends on mrc_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module mrc_checker
   import mrc_pkg::*;
(
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_tvalid,
   input wire logic                 req_tready,
   input wire logic                 req_tuser,
   input wire logic                 rsp_tvalid,
   input wire logic                 rsp_tready,
   input wire logic [RSP_W-1:0]     rsp_tdata,
   input wire logic                 rsp_tlast
);

   property p_rsp_hold;
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast);
   endproperty

   property p_decode_busy;
      req_tvalid && req_tready && req_tuser == OP_DECODE |=> !req_tready;
   endproperty

   property p_index_zero;
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[RSP_W-1:8] == '0;
   endproperty

   // a waiting result holds its payload
   `MRC_ASSERT(a_rsp_hold, clock, reset, p_rsp_hold, "rsp item changed while stalled")

   // one item at a time: no new item while a result is shown
   `MRC_ASSERT(a_busy, clock, reset, req_tready |-> !rsp_tvalid, "req ready while rsp valid")

   // a decode item keeps the block busy on the next cycle
   `MRC_ASSERT(a_decode_busy, clock, reset, p_decode_busy, "decode item did not start work")

   // only the final item of a run carries an index
   `MRC_ASSERT(a_index_zero, clock, reset, p_index_zero, "index on non-final item")

   // nothing is shown right after reset
   `MRC_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_tvalid, "rsp valid after reset")

endmodule

bind mixed_radix_index_converter mrc_checker u_mrc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

// File: sim/tb.sv
`timescale 1ns / 1ps
// self-checking bench for mixed_radix_index_converter: a directed table, then random phases
// depends on mrc_pkg and the converter rtl; stimulus, prediction and checks are all built in

module tb;
   import mrc_pkg::*;

   localparam int SETTLE      = 16;
   localparam int LIMIT       = 500000;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 12;

   // one result item as it leaves the block
   typedef struct packed {
      logic [LOCUS_W-1:0] locus;
      logic [DIG_W-1:0]   digit;
      logic [IDX_W-1:0]   index;
      logic               last;
   } conv_rsp_type;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   // one line of the directed table
   typedef struct packed {
      row_kind_type         kind;
      logic                 op;
      logic [IDX_W-1:0]     index;
      logic [DIG_W-1:0]     digit;
      logic [CSR_IDX_W-1:0] reg_idx;
      logic [CSR_W-1:0]     reg_data;
      logic                 typed;
      conv_rsp_type         want;
   } plan_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [REQ_W-1:0]     req_tdata = '0;
   logic                 req_tuser = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_W-1:0]     rsp_tdata;
   logic                 rsp_tlast;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_data = '0;

   // mirror of the block's registers and encode state
   logic [CNT_W-1:0]   count_reg = CNT_W'(1);
   logic [CSR_W-1:0]   radix_reg = 64'h2222_2222_2222_2222;
   logic [IDX_W-1:0]   acc_model = '0;
   logic [LOCUS_W-1:0] pos_model = '0;

   conv_rsp_type conversions[$];
   plan_row_type plan[$];
   conv_rsp_type got_rsp;
   conv_rsp_type want_rsp;
   int unsigned  errors = 0;
   int unsigned  cycles = 0;
   int unsigned  hold_left = 0;
   int unsigned  roll;
   bit           calm = 1'b0;

   mixed_radix_index_converter uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycles = cycles + 1;
      if (cycles == LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // loci in use, zero counting as one and the top clamped
   function automatic int unsigned loci_active();
      int unsigned n;
      n = 32'(count_reg);
      if (n == 0) n = 1;
      if (n > LOCI_MAX) n = LOCI_MAX;
      return n;
   endfunction

   // radix of one locus, a zero nibble counting as one
   function automatic logic [IDX_W-1:0] radix_at(int unsigned l);
      logic [DIG_W-1:0] r;
      r = radix_reg[l*DIG_W +: DIG_W];
      return (r == '0) ? IDX_W'(1) : IDX_W'(r);
   endfunction

   // digits of a decoded index, or the next encode step
   task automatic convert(input logic op, input logic [IDX_W-1:0] idx,
                          input logic [DIG_W-1:0] dig);
      int unsigned      n;
      int unsigned      l;
      int unsigned      p;
      logic [IDX_W-1:0] x;
      logic [IDX_W-1:0] r;
      conv_rsp_type     res;
      n = loci_active();
      if (op == OP_DECODE) begin
         x = idx;
         for (l = n; l > 0; l--) begin
            r = radix_at(l - 1);
            res.locus = LOCUS_W'(l - 1);
            res.digit = DIG_W'(x % r);
            res.index = '0;
            res.last  = (l == 1);
            conversions.push_back(res);
            x = x / r;
         end
      end else begin
         p = 32'(pos_model);
         acc_model = acc_model * radix_at(p) + IDX_W'(dig);
         // run ends here, also when the count was lowered below the position
         if (p + 1 >= n) begin
            res.locus = LOCUS_W'(n - 1);
            res.digit = dig;
            res.index = acc_model;
            res.last  = 1'b1;
            conversions.push_back(res);
            acc_model = '0;
            pos_model = '0;
         end else begin
            pos_model = LOCUS_W'(p + 1);
         end
      end
   endtask

   // mostly short gaps, a few long ones, none in calm stretches
   function automatic int unsigned idle_gap();
      int unsigned r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic push_req(input logic op, input logic [IDX_W-1:0] idx,
                           input logic [DIG_W-1:0] dig, input logic typed,
                           input conv_rsp_type want);
      int unsigned gap;
      gap = idle_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {{(REQ_W-IDX_W-DIG_W){1'b0}}, dig, idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      convert(op, idx, dig);
      // a typed row carries exactly one result, which replaces the predicted one
      if (typed) begin
         void'(conversions.pop_back());
         conversions.push_back(want);
      end
   endtask

   // register write once the block has gone quiet
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] data);
      req_tvalid <= 1'b0;
      while (conversions.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == REG_LOCUS_COUNT) count_reg = data[CNT_W-1:0];
      else radix_reg = data;
   endtask

   function automatic plan_row_type row_item(input logic op, input logic [IDX_W-1:0] idx,
                                             input logic [DIG_W-1:0] dig);
      plan_row_type s;
      s = '0;
      s.kind  = ROW_ITEM;
      s.op    = op;
      s.index = idx;
      s.digit = dig;
      return s;
   endfunction

   function automatic plan_row_type row_typed(input logic op, input logic [IDX_W-1:0] idx,
                                              input logic [DIG_W-1:0] dig,
                                              input logic [DIG_W-1:0] dig_out,
                                              input logic [IDX_W-1:0] idx_out);
      plan_row_type s;
      s = row_item(op, idx, dig);
      s.typed = 1'b1;
      s.want  = '{LOCUS_W'(0), dig_out, idx_out, 1'b1};
      return s;
   endfunction

   function automatic plan_row_type row_csr(input logic [CSR_IDX_W-1:0] idx,
                                            input logic [CSR_W-1:0] data);
      plan_row_type s;
      s = '0;
      s.kind     = ROW_CSR;
      s.reg_idx  = idx;
      s.reg_data = data;
      return s;
   endfunction

   function automatic logic [IDX_W-1:0] rand_index();
      case ($urandom_range(0, 5))
         0: return '1;
         1: return IDX_W'($urandom_range(0, 255));
         2: return IDX_W'($urandom_range(0, 65535));
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [CSR_W-1:0] rand_count();
      case ($urandom_range(0, 9))
         0: return CSR_W'(0);
         1: return CSR_W'(1);
         2: return CSR_W'(LOCI_MAX);
         3: return '1;
         4: return CSR_W'($urandom_range(0, 31));
         default: return CSR_W'($urandom_range(1, 4));
      endcase
   endfunction

   function automatic logic [CSR_W-1:0] rand_radix();
      logic [CSR_W-1:0] v;
      int unsigned      k;
      v = '0;
      case ($urandom_range(0, 5))
         0: v = '0;
         1: v = '1;
         2: v = {$urandom, $urandom};
         default: begin
            for (k = 0; k < LOCI_MAX; k++) v[k*DIG_W +: DIG_W] = DIG_W'($urandom_range(2, 4));
         end
      endcase
      return v;
   endfunction

   // next encode digit, now and then at or above the radix
   function automatic logic [DIG_W-1:0] rand_digit();
      if ($urandom_range(0, 4) == 0) return DIG_W'($urandom_range(0, 15));
      return DIG_W'($urandom_range(0, radix_at(32'(pos_model)) - 1));
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      errors = errors + 1;
      $display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
   endtask

   // result side stalls
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (calm) begin
         rsp_tready <= 1'b1;
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 60) begin
            rsp_tready <= 1'b1;
         end else if (roll < 95) begin
            rsp_tready <= 1'b0;
            hold_left = $urandom_range(0, 3);
         end else begin
            rsp_tready <= 1'b0;
            hold_left = $urandom_range(10, 40);
         end
      end
   end

   // compare each accepted result against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_rsp = '{rsp_tdata[3:0], rsp_tdata[7:4], rsp_tdata[39:8], rsp_tlast};
         if (conversions.size() == 0) begin
            report_mismatch("result with none pending", 64'(got_rsp), 64'd0);
         end else begin
            want_rsp = conversions.pop_front();
            if (got_rsp.locus !== want_rsp.locus)
               report_mismatch("locus", 64'(got_rsp.locus), 64'(want_rsp.locus));
            if (got_rsp.digit !== want_rsp.digit)
               report_mismatch("digit_out", 64'(got_rsp.digit), 64'(want_rsp.digit));
            if (got_rsp.index !== want_rsp.index)
               report_mismatch("index_out", 64'(got_rsp.index), 64'(want_rsp.index));
            if (got_rsp.last !== want_rsp.last)
               report_mismatch("last", 64'(got_rsp.last), 64'(want_rsp.last));
         end
      end
   end

   initial begin
      int unsigned  phase;
      int unsigned  done_items;
      int unsigned  run_len;
      int unsigned  k;
      conv_rsp_type none;
      none = '0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset settings: one locus of radix two
      plan.push_back(row_typed(OP_DECODE, 32'h0000_0000, 4'h0, 4'h0, 32'h0));
      plan.push_back(row_typed(OP_DECODE, 32'hFFFF_FFFF, 4'h0, 4'h1, 32'h0));
      plan.push_back(row_typed(OP_ENCODE, 32'h0000_0000, 4'h0, 4'h0, 32'h0));
      plan.push_back(row_typed(OP_ENCODE, 32'h0000_0000, 4'hF, 4'hF, 32'hF));
      // widest count, every radix fifteen
      plan.push_back(row_csr(REG_LOCUS_COUNT, 64'd16));
      plan.push_back(row_csr(REG_RADIX_LIST, '1));
      plan.push_back(row_item(OP_DECODE, 32'hFFFF_FFFF, 4'h0));
      plan.push_back(row_item(OP_DECODE, 32'h0000_0000, 4'h0));
      // nine digits of fifteen overflow the accumulator
      plan.push_back(row_csr(REG_LOCUS_COUNT, 64'd9));
      for (k = 0; k < 9; k++) plan.push_back(row_item(OP_ENCODE, 32'h0, 4'hF));
      // zero radices and a zero count (upper data bits ignored)
      plan.push_back(row_csr(REG_RADIX_LIST, 64'h0));
      plan.push_back(row_csr(REG_LOCUS_COUNT, 64'hFFFF_FFFF_FFFF_FFE0));
      plan.push_back(row_typed(OP_DECODE, 32'hDEAD_BEEF, 4'h0, 4'h0, 32'h0));
      plan.push_back(row_typed(OP_ENCODE, 32'h0, 4'h9, 4'h9, 32'h9));
      // count above the maximum, mixed radices with a zero nibble
      plan.push_back(row_csr(REG_LOCUS_COUNT, '1));
      plan.push_back(row_csr(REG_RADIX_LIST, 64'h0123_4567_89AB_CDEF));
      plan.push_back(row_item(OP_DECODE, 32'h89AB_CDEF, 4'h0));
      // count lowered in the middle of an encode run, decode in between
      plan.push_back(row_csr(REG_LOCUS_COUNT, 64'd4));
      plan.push_back(row_item(OP_ENCODE, 32'h0, 4'h1));
      plan.push_back(row_item(OP_ENCODE, 32'h0, 4'h2));
      plan.push_back(row_item(OP_ENCODE, 32'h0, 4'h3));
      plan.push_back(row_csr(REG_LOCUS_COUNT, 64'd2));
      plan.push_back(row_item(OP_DECODE, 32'd1000, 4'h0));
      plan.push_back(row_item(OP_ENCODE, 32'h0, 4'h5));

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) write_reg(plan[i].reg_idx, plan[i].reg_data);
         else push_req(plan[i].op, plan[i].index, plan[i].digit, plan[i].typed, plan[i].want);
      end

      // random phases: new settings, then mostly whole encode runs and decodes
      for (phase = 0; phase < PHASES; phase++) begin
         if ($urandom_range(0, 1) == 0) begin
            write_reg(REG_LOCUS_COUNT, rand_count());
            write_reg(REG_RADIX_LIST, rand_radix());
         end else begin
            write_reg(REG_RADIX_LIST, rand_radix());
            write_reg(REG_LOCUS_COUNT, rand_count());
         end
         calm = ($urandom_range(0, 3) == 0);
         done_items = 0;
         while (done_items < PHASE_ITEMS) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: begin
                  push_req(OP_DECODE, rand_index(), DIG_W'($urandom), 1'b0, none);
                  done_items++;
               end
               4, 5, 6, 7: begin
                  // finish the current run
                  if (pos_model >= loci_active()) run_len = 1;
                  else run_len = loci_active() - pos_model;
                  for (k = 0; k < run_len; k++) begin
                     push_req(OP_ENCODE, $urandom, rand_digit(), 1'b0, none);
                     done_items++;
                  end
               end
               8: begin
                  // broken run: a few digits only
                  run_len = $urandom_range(1, 3);
                  for (k = 0; k < run_len; k++) begin
                     push_req(OP_ENCODE, $urandom, rand_digit(), 1'b0, none);
                     done_items++;
                  end
               end
               default: begin
                  push_req(1'($urandom_range(0, 1)), $urandom, DIG_W'($urandom), 1'b0, none);
                  done_items++;
               end
            endcase
         end
      end

      // drain and let stray results show up
      req_tvalid <= 1'b0;
      calm = 1'b0;
      while (conversions.size() != 0) @(posedge clock);
      repeat (SETTLE * 10) @(posedge clock);
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
